@@ rtl/core/sha256_pkg.sv @@
`default_nettype none

package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned TotalBits  = 61;

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  localparam logic [31:0] INITIAL_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha256_hash_engine.sv @@
`default_nettype none

// SHA-256 engine. Message words are taken one per cycle while the engine is
// idle; each item is a big-endian word with a count of valid leading bytes,
// and a short word or a flagged final word closes the message. A full block
// of 16 words is compressed by one shared round unit, one round per cycle, and
// the result is then folded into the chaining value; no item is taken during
// the rounds or the fold. After the final word the padding and 64-bit bit
// length are shifted into the schedule window one word per cycle, with one or
// two closing compressions, and the eight digest words then leave one per
// accepted cycle, word 0 first, the last one flagged.
module sha256_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        final_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       digest_index,
  output logic             last_result
);
  import sha256_pkg::*;

  state_t state, state_next;

  // schedule window: win[0] is the word for the current round
  logic [31:0] win [0:BlockWords-1];
  logic [31:0] chain [0:7];
  logic [31:0] vars [0:7];
  logic [4:0]  word_cnt;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic [TotalBits-1:0] total;
  logic        mark_pending;
  logic        last_block;
  logic        ending;

  logic        in_acc, out_acc;
  logic [2:0]  cnt_eff;
  logic        fin_eff;
  logic [31:0] keep_mask, mark_bits, word_in;
  logic [31:0] pad_word, sched_word;
  logic        shift_en;
  logic [31:0] shift_word;
  logic [31:0] t1, t2;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    cnt_eff = (byte_count > 3'd4) ? 3'd4 : byte_count;
    fin_eff = final_word || (cnt_eff != 3'd4);
    case (cnt_eff)
      3'd0:    begin keep_mask = 32'h0000_0000; mark_bits = 32'h8000_0000; end
      3'd1:    begin keep_mask = 32'hff00_0000; mark_bits = 32'h0080_0000; end
      3'd2:    begin keep_mask = 32'hffff_0000; mark_bits = 32'h0000_8000; end
      3'd3:    begin keep_mask = 32'hffff_ff00; mark_bits = 32'h0000_0080; end
      default: begin keep_mask = 32'hffff_ffff; mark_bits = 32'h0000_0000; end
    endcase
    word_in = (data_word & keep_mask) | mark_bits;
  end

  // padding word for the next free slot of the block
  always_comb begin
    if (mark_pending) begin
      pad_word = PAD_MARK;
    end else if (word_cnt == 5'd14) begin
      pad_word = total[TotalBits-1:TotalBits-32];
    end else if (word_cnt == 5'd15 && last_block) begin
      pad_word = {total[TotalBits-33:0], 3'b000};
    end else begin
      pad_word = 32'h0;
    end
  end

  always_comb begin
    sched_word = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    t1 = vars[7] + big_sigma1(vars[4])
       + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6])) + ROUND_K[rnd] + win[0];
    t2 = big_sigma0(vars[0])
       + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  always_comb begin
    shift_en   = 1'b0;
    shift_word = sched_word;
    if (in_acc) begin
      shift_en   = 1'b1;
      shift_word = word_in;
    end else if (state == ST_PAD && !word_cnt[4]) begin
      shift_en   = 1'b1;
      shift_word = pad_word;
    end else if (state == ST_ROUND) begin
      shift_en   = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (fin_eff) begin
            state_next = ST_PAD;
          end else if (word_cnt == 5'd15) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (word_cnt[4]) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'(Rounds - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (last_block) begin
          state_next = ST_OUT;
        end else if (ending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall && out_idx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall     = (state != ST_IDLE);
    out_valid    = (state == ST_OUT);
    digest_word  = chain[out_idx];
    digest_index = out_idx;
    last_result  = (out_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlockWords-1] <= shift_word;
    end
    if (state == ST_ROUND) begin
      vars[0] <= t1 + t2;
      vars[1] <= vars[0];
      vars[2] <= vars[1];
      vars[3] <= vars[2];
      vars[4] <= vars[3] + t1;
      vars[5] <= vars[4];
      vars[6] <= vars[5];
      vars[7] <= vars[6];
    end else if (state_next == ST_ROUND) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= chain[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      word_cnt     <= '0;
      rnd          <= '0;
      out_idx      <= '0;
      total        <= '0;
      mark_pending <= 1'b0;
      last_block   <= 1'b0;
      ending       <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INITIAL_HASH[i];
      end
    end else begin
      state <= state_next;
      if (in_acc) begin
        word_cnt <= word_cnt + 5'd1;
        total    <= total + TotalBits'(cnt_eff);
        if (fin_eff) begin
          ending       <= 1'b1;
          mark_pending <= (cnt_eff == 3'd4);
        end
      end else if (state == ST_PAD && !word_cnt[4]) begin
        word_cnt     <= word_cnt + 5'd1;
        mark_pending <= 1'b0;
        if (!mark_pending && word_cnt == 5'd14) begin
          last_block <= 1'b1;
        end
      end
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end else begin
        rnd <= '0;
      end
      if (state == ST_ADD) begin
        word_cnt <= '0;
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          // start a fresh message
          total      <= '0;
          ending     <= 1'b0;
          last_block <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            chain[i] <= INITIAL_HASH[i];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  localparam int IdleLimit   = 5000;
  localparam int HoldCycles  = 400;
  localparam int PhaseWords  = 34;

  typedef enum int {
    PH_DIRECT,
    PH_FREE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        fin;
  } msg_word_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count = '0;
  logic        final_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        last_result;

  sha256_hash_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .final_word   (final_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .digest_index (digest_index),
    .last_result  (last_result)
  );

  always #6 clk = ~clk;

  phase_t    phase = PH_DIRECT;
  int        gap_pct = 0;
  int        stall_pct = 0;
  msg_word_t word_queue[$];
  msg_word_t cur_word;
  digest_t   digest_due[$];
  int        words_pushed = 0;
  int        words_taken = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        hold_left = 0;
  logic      hold_used = 1'b0;

  // running hash state of the message in flight
  logic [31:0] blk [16];
  logic [31:0] chain [8];
  logic [60:0] byte_total;
  int          fill_pos;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void put_byte(input int pos, input logic [7:0] b);
    blk[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = b;
  endfunction

  function automatic void sha_compress();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      sched[i] = (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10))
               + sched[i-7]
               + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + sched[i-16];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[i] + sched[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  // absorb one accepted word; on a closing word pad, finish and queue the digest
  function automatic void sha_take(input msg_word_t w);
    int          n;
    int          pos;
    logic        closes;
    logic [63:0] bit_len;
    digest_t     dw;
    n = (w.cnt > 3'd4) ? 4 : int'(w.cnt);
    closes = w.fin || (n < 4);
    for (int k = 0; k < n; k++) put_byte((fill_pos + k) & 63, w.data[31 - 8 * k -: 8]);
    byte_total = byte_total + 61'(n);
    pos = fill_pos + n;
    if (!closes) begin
      fill_pos = pos & 63;
      if (pos >= 64) sha_compress();
      return;
    end
    if (pos >= 64) begin
      sha_compress();
      pos = 0;
    end
    put_byte(pos, 8'h80);
    for (int k = pos + 1; k < 64; k++) put_byte(k, 8'h00);
    if (pos >= 56) begin
      sha_compress();
      for (int k = 0; k < 16; k++) blk[k] = '0;
    end
    bit_len = {byte_total, 3'b000};
    blk[14] = bit_len[63:32];
    blk[15] = bit_len[31:0];
    sha_compress();
    for (int k = 0; k < 8; k++) begin
      dw.word = chain[k];
      dw.idx = 3'(k);
      dw.is_last = (k == 7);
      digest_due.push_back(dw);
    end
    chain = INITIAL_HASH;
    byte_total = '0;
    fill_pos = 0;
  endfunction

  // message word driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sha_take(cur_word);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          cur_word = word_queue.pop_front();
          in_valid <= 1'b1;
          data_word <= cur_word.data;
          byte_count <= cur_word.cnt;
          final_word <= cur_word.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // digest side back-pressure, with one long hold in the pressure phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (phase == PH_PRESSURE && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // digest checker
  always @(posedge clk) begin
    digest_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (digest_due.size() == 0) begin
        $display("%0t: unexpected digest item: word %h index %0d last %b",
                 $time, digest_word, digest_index, last_result);
        errors++;
      end else begin
        exp_w = digest_due.pop_front();
        if (digest_word !== exp_w.word) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, exp_w.word, digest_word);
          errors++;
        end
        if (digest_index !== exp_w.idx) begin
          $display("%0t: digest_index mismatch: expected %0d, actual %0d",
                   $time, exp_w.idx, digest_index);
          errors++;
        end
        if (last_result !== exp_w.is_last) begin
          $display("%0t: last_result mismatch: expected %b, actual %b",
                   $time, exp_w.is_last, last_result);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
    msg_word_t w;
    w.data = data;
    w.cnt = cnt;
    w.fin = fin;
    word_queue.push_back(w);
    words_pushed++;
  endtask

  // full words with random counts 4..7, then one closing word
  task automatic push_message();
    int          n;
    int          sel;
    logic [2:0]  cnt;
    sel = $urandom_range(9);
    if (sel < 6) n = $urandom_range(6);
    else if (sel < 9) n = $urandom_range(17, 12);
    else n = $urandom_range(33, 28);
    for (int i = 0; i < n; i++) push_word($urandom, 3'($urandom_range(7, 4)), 1'b0);
    cnt = 3'($urandom_range(4));
    push_word($urandom, cnt, (cnt == 3'd4) ? 1'b1 : 1'($urandom_range(1)));
  endtask

  task automatic enter_phase(input phase_t p, input int gap, input int stall);
    phase = p;
    gap_pct = gap;
    stall_pct = stall;
  endtask

  task automatic drain();
    while (words_taken < words_pushed) @(negedge clk);
  endtask

  initial begin
    int start_count;
    for (int k = 0; k < 16; k++) blk[k] = '0;
    chain = INITIAL_HASH;
    byte_total = '0;
    fill_pos = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    enter_phase(PH_DIRECT, 0, 0);
    push_word(32'hFFFF_FFFF, 3'd0, 1'b1);        // empty message
    push_word(32'h6162_63FF, 3'd3, 1'b0);        // "abc", short word closes, tail ignored
    push_word(32'hFFFF_FFFF, 3'd7, 1'b0);        // oversized counts act as four
    push_word(32'h0000_0000, 3'd5, 1'b0);
    push_word(32'h1234_5678, 3'd6, 1'b0);
    push_word(32'hDEAD_BEEF, 3'd0, 1'b0);        // empty word closes without final flag
    push_word(32'h0000_0000, 3'd1, 1'b1);
    push_word(32'hA5A5_A5A5, 3'd4, 1'b1);
    // 56 bytes: length no longer fits, two closing blocks
    for (int i = 0; i < 13; i++) push_word(32'hFFFF_FFFF ^ (i << 4), 3'd4, 1'b0);
    push_word(32'h0000_0000, 3'd4, 1'b1);
    drain();

    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      case (phase_t'(p))
        PH_SRC_IDLE:   enter_phase(phase_t'(p), 61, 0);
        PH_SINK_STALL: enter_phase(phase_t'(p), 0, 61);
        PH_BOTH:       enter_phase(phase_t'(p), 29, 29);
        default:       enter_phase(phase_t'(p), 0, 0);
      endcase
      start_count = words_pushed;
      while (words_pushed - start_count < PhaseWords) push_message();
      drain();
    end

    // queue everything up front so the sender keeps offering during the hold
    enter_phase(PH_PRESSURE, 0, 0);
    push_word(32'hC0FF_EE00, 3'd2, 1'b1);
    for (int i = 0; i < 4; i++) push_message();
    drain();

    while (digest_due.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_hash_engine.sv
dv/tb.sv
